>>> sv/ptt_pkg.sv
// Package for the page table translator: widths, table depth, register indexes
// and the back end state type. Used by every module of the block.
package ptt_pkg;
   localparam int MaxEntries = 64;
   localparam int SlotW = $clog2(MaxEntries);
   localparam int CountW = $clog2(MaxEntries + 1);
   localparam int AddrW = 32;
   localparam int PhysW = 22;
   localparam int PsizeW = 16;
   localparam int CfgW = 16;
   localparam int QueueDepth = 2;

   localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
   localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
   localparam logic [1:0] REG_POLICY = 2'd2;

   typedef struct packed {
      logic [AddrW-1:0] page;
      logic [PsizeW-1:0] offset;
   } ptt_job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_MULT, ST_SHIFT, ST_DONE
   } ptt_state_type;
endpackage

>>> sv/ptt_front.sv
// Front end: accepts address beats and splits them into page number and offset
// with a bit-serial restoring divider. Depends on ptt_pkg.
module ptt_front import ptt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [AddrW-1:0]    req_virtual_address,
   input  logic [PsizeW-1:0]   psize,
   output logic                job_valid,
   input  logic                job_stall,
   output ptt_job_type         job
);
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [AddrW-1:0]    quo_ff, quo_in;
   logic [PsizeW:0]     rem_ff, rem_in;
   logic [PsizeW:0]     trial;
   logic [PsizeW:0]     shifted;

   assign req_stall = busy_ff | done_ff;
   assign job_valid = done_ff;
   assign job.page = quo_ff;
   assign job.offset = rem_ff[PsizeW-1:0];

   // One quotient bit per cycle: shift in the next dividend bit, try to subtract.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      shifted = {rem_ff[PsizeW-1:0], quo_ff[AddrW-1]};
      trial = shifted - {1'b0, psize};
      if (!busy_ff && !done_ff && req_valid) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         quo_in = req_virtual_address;
         rem_in = '0;
      end else if (busy_ff) begin
         if (!trial[PsizeW]) begin
            rem_in = trial;
            quo_in = {quo_ff[AddrW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[AddrW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(AddrW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && !job_stall) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end
endmodule

>>> sv/ptt_queue.sv
// Short queue between front and back end. Depends on ptt_pkg.
module ptt_queue import ptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  ptt_job_type  in_job,
   output logic         out_valid,
   input  logic         out_stall,
   output ptt_job_type  out_job
);
   localparam int PtrW = $clog2(QueueDepth);
   ptt_job_type         mem_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]       cnt_ff, cnt_in;
   logic                push, pop;

   assign in_stall = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_job = mem_ff[rd_ff];
   assign push = in_valid & ~in_stall;
   assign pop = out_valid & ~out_stall;

   // Pointer and fill count update.
   always_comb begin
      wr_in = push ? PtrW'((wr_ff + 1'b1) % QueueDepth) : wr_ff;
      rd_in = pop ? PtrW'((rd_ff + 1'b1) % QueueDepth) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

>>> sv/ptt_back.sv
// Back end: searches the ordered table one slot a cycle, shifts entries one a cycle
// on an eviction or a hit under policy 0, and forms the physical address on a hit. Depends on ptt_pkg.
module ptt_back import ptt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_stall,
   input  ptt_job_type         job,
   input  logic [PsizeW-1:0]   psize,
   input  logic [CountW-1:0]   limit,
   input  logic                policy,
   input  logic                clear,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_fault,
   output logic [PhysW-1:0]    rsp_physical_address
);
   ptt_state_type       state_ff, state_in;
   logic [AddrW-1:0]    page_mem [MaxEntries];
   logic [SlotW-1:0]    frame_mem [MaxEntries];
   logic [AddrW-1:0]    page_ff;
   logic [PsizeW-1:0]   off_ff;
   logic [CountW-1:0]   used_ff, used_in;
   logic [CountW-1:0]   eff;
   logic [CountW-1:0]   pos_ff, pos_in;
   logic [CountW-1:0]   last_ff, last_in;
   logic [SlotW-1:0]    frame_ff, frame_in;
   logic                hit_ff, hit_in;
   logic [AddrW-1:0]    rd_page_ff;
   logic [SlotW-1:0]    rd_frame_ff;
   logic [SlotW-1:0]    rd_idx;
   logic [PhysW-1:0]    prod_ff;
   logic                out_valid_ff, out_valid_in;
   logic                out_fault_ff;
   logic [PhysW-1:0]    out_addr_ff;
   logic                take, emit, match;
   logic                wr_en;
   logic [SlotW-1:0]    wr_idx;
   logic [AddrW-1:0]    wr_page;
   logic [SlotW-1:0]    wr_frame;
   logic [SlotW-1:0]    pos_idx;
   logic [SlotW-1:0]    next_idx;

   assign eff = (used_ff > limit) ? limit : used_ff;
   assign job_stall = (state_ff != ST_IDLE);
   assign take = job_valid & (state_ff == ST_IDLE);
   assign emit = (state_ff == ST_DONE) & (!out_valid_ff | !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_fault = out_fault_ff;
   assign rsp_physical_address = out_addr_ff;
   assign pos_idx = pos_ff[SlotW-1:0];
   assign next_idx = pos_idx + SlotW'(1);
   // The registered read data always holds the slot at pos_ff while searching.
   assign match = (pos_ff < eff) && (rd_page_ff == page_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (pos_ff >= eff) state_in = (eff < limit) ? ST_DONE : ST_SHIFT;
            else if (match)
               state_in = policy ? ST_MULT : ST_SHIFT;
         end
         ST_SHIFT: if (pos_ff >= last_ff) state_in = hit_ff ? ST_MULT : ST_DONE;
         ST_MULT: state_in = ST_DONE;
         ST_DONE: if (emit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control, read address and table write selection.
   always_comb begin
      used_in = used_ff;
      pos_in = pos_ff;
      last_in = last_ff;
      frame_in = frame_ff;
      hit_in = hit_ff;
      rd_idx = '0;
      wr_en = 1'b0;
      wr_idx = pos_idx;
      wr_page = page_ff;
      wr_frame = frame_ff;
      case (state_ff)
         ST_IDLE: begin
            pos_in = '0;
            hit_in = 1'b0;
         end
         ST_SEARCH: begin
            if (pos_ff >= eff) begin
               if (eff < limit) begin
                  // Miss with room: append into the first free slot.
                  wr_en = 1'b1;
                  wr_idx = eff[SlotW-1:0];
                  wr_frame = eff[SlotW-1:0];
                  used_in = eff + 1'b1;
               end else begin
                  // Miss on a full table: frame_ff already holds the oldest
                  // slot's frame; fetch slot one to start the shift down.
                  rd_idx = SlotW'(1);
                  pos_in = '0;
                  last_in = limit - 1'b1;
               end
            end else begin
               // Keep the oldest frame for an eviction, or the hit frame.
               if (pos_ff == '0 || match) frame_in = rd_frame_ff;
               rd_idx = next_idx;
               if (match) begin
                  hit_in = 1'b1;
                  last_in = eff - 1'b1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            if (pos_ff >= last_ff) begin
               wr_en = 1'b1;
               wr_idx = last_ff[SlotW-1:0];
            end else begin
               // The read data holds the next younger slot; move it down.
               wr_en = 1'b1;
               wr_page = rd_page_ff;
               wr_frame = rd_frame_ff;
               pos_in = pos_ff + 1'b1;
               rd_idx = pos_idx + SlotW'(2);
            end
         end
         default: ;
      endcase
      if (clear) used_in = '0;
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_valid && !rsp_stall) out_valid_in = 1'b0;
      if (emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff <= pos_in;
      last_ff <= last_in;
      frame_ff <= frame_in;
      hit_ff <= hit_in;
      if (take) begin
         page_ff <= job.page;
         off_ff <= job.offset;
      end
      if (state_ff == ST_MULT)
         prod_ff <= ({{(PhysW-SlotW){1'b0}}, frame_ff} * {{(PhysW-PsizeW){1'b0}}, psize})
                    + {{(PhysW-PsizeW){1'b0}}, off_ff};
      if (emit) begin
         out_fault_ff <= !hit_ff;
         out_addr_ff <= hit_ff ? prod_ff : '0;
      end
   end

   // Table storage with one registered read and one write a cycle.
   always_ff @(posedge clock) begin
      rd_page_ff <= page_mem[rd_idx];
      rd_frame_ff <= frame_mem[rd_idx];
      if (wr_en) begin
         page_mem[wr_idx] <= wr_page;
         frame_mem[wr_idx] <= wr_frame;
      end
   end
endmodule

>>> sv/page_table_translate_lru_fifo_top.sv
// Top level of the page table translator: registers, front end divider,
// queue and table back end. Depends on ptt_pkg, ptt_front, ptt_queue, ptt_back.
//
//   channel   ports                          direction
//   request   req_valid/req_stall/req_*      in, one virtual address per beat
//   response  rsp_valid/rsp_stall/rsp_*      out, fault and physical address
//   csr       csr_write/csr_index/csr_data   in, register writes
//
// The front end has a one-bit-per-cycle divider and takes no new beat until its last job is queued.
// The back end searches one slot a cycle and shifts one slot a cycle, and takes
// no new item until its result is registered; the two ends overlap.
// Reset is synchronous; it empties the table and loads default registers.
// A stall on the response side holds the back end; the queue keeps the front busy.
module page_table_translate_lru_fifo_top import ptt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [AddrW-1:0]    req_virtual_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_fault,
   output logic [PhysW-1:0]    rsp_physical_address,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [CfgW-1:0]     csr_data
);
   logic [PsizeW-1:0]   psize_ff;
   logic [6:0]          fcount_ff;
   logic                policy_ff;
   logic [PsizeW-1:0]   psize;
   logic [CountW-1:0]   limit;
   logic                clear;
   logic                f_valid, f_stall, b_valid, b_stall;
   ptt_job_type         f_job, b_job;

   // Effective page size and table size.
   assign psize = (psize_ff == '0) ? PsizeW'(1) : psize_ff;
   assign limit = (fcount_ff == '0) ? CountW'(1) :
                  (fcount_ff > 7'(MaxEntries)) ? CountW'(MaxEntries) : CountW'(fcount_ff);
   assign clear = csr_write && (csr_index == REG_PAGE_SIZE ||
                  csr_index == REG_FRAME_COUNT || csr_index == REG_POLICY);

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= PsizeW'(1);
         fcount_ff <= 7'd16;
         policy_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PAGE_SIZE: psize_ff <= csr_data;
            REG_FRAME_COUNT: fcount_ff <= csr_data[6:0];
            REG_POLICY: policy_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   ptt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_virtual_address,
      .psize, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
   );

   ptt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
      .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
   );

   ptt_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
      .psize, .limit, .policy(policy_ff), .clear,
      .rsp_valid, .rsp_stall, .rsp_fault, .rsp_physical_address
   );
endmodule
